// ===== rtl/core/tts_pkg.sv =====
// Shared types and constants of the text terminal screen controller.
// No dependencies; imported by tts_decode and text_terminal_screen_controller.
`default_nettype none

package tts_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;

  // Character codes
  localparam logic [6:0] CH_BS    = 7'o010;
  localparam logic [6:0] CH_HT    = 7'o011;
  localparam logic [6:0] CH_LF    = 7'o012;
  localparam logic [6:0] CH_CR    = 7'o015;
  localparam logic [6:0] CH_ESC   = 7'o033;
  localparam logic [6:0] CH_SPACE = 7'o040;
  localparam logic [6:0] CH_SLASH = 7'o057;
  localparam logic [6:0] CH_GFX0  = 7'o136;
  localparam logic [6:0] CH_GFX1  = 7'o137;
  localparam logic [6:0] CH_DEL   = 7'o177;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_B     = 7'h42;
  localparam logic [6:0] CH_C     = 7'h43;
  localparam logic [6:0] CH_D     = 7'h44;
  localparam logic [6:0] CH_F     = 7'h46;
  localparam logic [6:0] CH_G     = 7'h47;
  localparam logic [6:0] CH_H     = 7'h48;
  localparam logic [6:0] CH_I     = 7'h49;
  localparam logic [6:0] CH_J     = 7'h4A;
  localparam logic [6:0] CH_K     = 7'h4B;
  localparam logic [6:0] CH_Y     = 7'h59;
  localparam logic [6:0] CH_Z     = 7'h5A;

  // Tab stop spacing
  localparam logic [6:0] TAB_STEP = 7'd8;

  // Direct addressing phases
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ROW  = 2'd1;
  localparam logic [1:0] PH_COL  = 2'd2;

  // Screen store operations requested by the decoder
  localparam logic [1:0] OP_NONE      = 2'd0;
  localparam logic [1:0] OP_FILL      = 2'd1;
  localparam logic [1:0] OP_SCROLL_UP = 2'd2;
  localparam logic [1:0] OP_SCROLL_DN = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [6:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic       reply_valid;
    logic [6:0] reply_byte;
    logic [6:0] cell_value;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       last;
  } out_word_t;

  // Terminal state as seen by the decoder
  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic       esc;
    logic [1:0] phase;
    logic [6:0] prow;
    logic       gfx;
  } term_t;

  // Decoder verdict for one received character
  typedef struct packed {
    term_t      nxt;
    logic       wr_en;
    logic [6:0] wr_val;
    logic [1:0] op;
    logic [4:0] end_row;
    logic       ident;
  } act_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_terminal_screen_controller.sv =====
// Top level of the text terminal screen controller: screen store and sequencer.
// Depends on tts_pkg and tts_decode.
//
// Input channel in_valid/in_ready/in_data carries one word per item: a
// received character (kind 0) or a read of one screen cell (kind 1). The
// result channel out_valid/out_ready/out_data returns one word per item, or
// three for the identify sequence, the final one flagged by last.
// One item is handled at a time; in_ready is high only while the sequencer
// is idle. A plain character passes through the decode and emit states; a
// cell read also waits in the read-wait state for the store. Scrolls and
// erases walk the screen store through its single write port: a scroll
// copies each cell in a read state and a write state; erase to end of
// screen clears one cell per cycle. After reset the store is cleared to
// spaces with in_ready held low.
// The result sits in an output register; while the receiver stalls it holds,
// and a new item may already be accepted and worked on. The sequencer only
// waits when it has a further result to hand over.
`default_nettype none

module text_terminal_screen_controller #(
  parameter int COLUMNS = tts_pkg::COLUMNS_DEF,
  parameter int ROWS    = tts_pkg::ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tts_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tts_pkg::out_word_t     out_data
);
  import tts_pkg::*;

  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int AW        = RW + CW;
  localparam int MEM_DEPTH = ROWS * (2 ** CW);

  localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);
  localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
  localparam logic [4:0] PEN_ROW  = 5'(ROWS - 2);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_RDWAIT  = 3'd2;
  localparam logic [2:0] S_COPY_RD = 3'd3;
  localparam logic [2:0] S_COPY_WR = 3'd4;
  localparam logic [2:0] S_FILL    = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0] state_r, state_nxt;
  term_t      term_r, term_nxt;
  in_word_t   in_r;
  logic [4:0] ptr_row_r, ptr_row_nxt;
  logic [6:0] ptr_col_r, ptr_col_nxt;
  logic [4:0] end_row_r, end_row_nxt;
  logic       up_r, up_nxt;
  logic       clr_r, clr_nxt;
  logic       ident_r, ident_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [6:0] cell_r, cell_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_r, out_nxt;

  // screen store
  logic [6:0]    mem [MEM_DEPTH];
  logic [6:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [6:0]    wr_data;
  logic          wr_en;

  act_t       act;
  logic [4:0] rd_row_sat;
  logic [6:0] rd_col_sat;
  logic [4:0] src_row;
  logic       slot_free;
  logic [6:0] reply_byte;

  tts_decode #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_decode (
    .char_code(in_r.char_code),
    .cur      (term_r),
    .act      (act)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  // read item address, saturated to the screen
  assign rd_row_sat = ({1'b0, in_r.read_row} >= 6'(ROWS)) ? LAST_ROW : in_r.read_row;
  assign rd_col_sat = ({1'b0, in_r.read_col} >= 8'(COLUMNS)) ? LAST_COL : in_r.read_col;

  // source row of a scroll copy
  assign src_row = up_r ? ptr_row_r + 5'd1 : ptr_row_r - 5'd1;

  // identify reply bytes in order
  always_comb begin
    unique case (idx_r)
      2'd0:    reply_byte = CH_ESC;
      2'd1:    reply_byte = CH_SLASH;
      default: reply_byte = CH_K;
    endcase
  end

  // Store port selection
  always_comb begin
    rd_addr = {rd_row_sat[RW-1:0], rd_col_sat[CW-1:0]};
    wr_addr = {ptr_row_r[RW-1:0], ptr_col_r[CW-1:0]};
    wr_data = CH_SPACE;
    wr_en   = 1'b0;
    unique case (state_r)
      S_DECODE: begin
        wr_addr = {term_r.row[RW-1:0], term_r.col[CW-1:0]};
        wr_data = act.wr_val;
        wr_en   = !in_r.kind && act.wr_en;
      end
      S_COPY_RD: rd_addr = {src_row[RW-1:0], ptr_col_r[CW-1:0]};
      S_COPY_WR: begin
        wr_data = rd_data_r;
        wr_en   = 1'b1;
      end
      S_FILL: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    term_nxt      = term_r;
    ptr_row_nxt   = ptr_row_r;
    ptr_col_nxt   = ptr_col_r;
    end_row_nxt   = end_row_r;
    up_nxt        = up_r;
    clr_nxt       = clr_r;
    ident_nxt     = ident_r;
    idx_nxt       = idx_r;
    cell_nxt      = cell_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end

      S_DECODE: begin
        cell_nxt  = '0;
        ident_nxt = 1'b0;
        idx_nxt   = '0;
        if (in_r.kind) begin
          state_nxt = S_RDWAIT;
        end else begin
          term_nxt  = act.nxt;
          ident_nxt = act.ident;
          unique case (act.op)
            OP_FILL: begin
              ptr_row_nxt = term_r.row;
              ptr_col_nxt = term_r.col;
              end_row_nxt = act.end_row;
              state_nxt   = S_FILL;
            end
            OP_SCROLL_UP: begin
              ptr_row_nxt = '0;
              ptr_col_nxt = '0;
              up_nxt      = 1'b1;
              state_nxt   = S_COPY_RD;
            end
            OP_SCROLL_DN: begin
              ptr_row_nxt = LAST_ROW;
              ptr_col_nxt = '0;
              up_nxt      = 1'b0;
              state_nxt   = S_COPY_RD;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end

      S_RDWAIT: begin
        cell_nxt  = rd_data_r;
        state_nxt = S_EMIT;
      end

      S_COPY_RD: state_nxt = S_COPY_WR;

      // copy one cell, then step; the row left over is blanked
      S_COPY_WR: begin
        state_nxt = S_COPY_RD;
        if (ptr_col_r == LAST_COL) begin
          ptr_col_nxt = '0;
          if (up_r ? (ptr_row_r == PEN_ROW) : (ptr_row_r == 5'd1)) begin
            ptr_row_nxt = up_r ? LAST_ROW : 5'd0;
            end_row_nxt = up_r ? LAST_ROW : 5'd0;
            state_nxt   = S_FILL;
          end else begin
            ptr_row_nxt = src_row;
          end
        end else begin
          ptr_col_nxt = ptr_col_r + 7'd1;
        end
      end

      // blank one cell, row-major up to the end of end_row
      S_FILL: begin
        if (ptr_col_r == LAST_COL) begin
          ptr_col_nxt = '0;
          if (ptr_row_r == end_row_r) begin
            state_nxt = clr_r ? S_IDLE : S_EMIT;
            clr_nxt   = 1'b0;
          end else begin
            ptr_row_nxt = ptr_row_r + 5'd1;
          end
        end else begin
          ptr_col_nxt = ptr_col_r + 7'd1;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.reply_valid    = ident_r;
          out_nxt.reply_byte     = ident_r ? reply_byte : 7'd0;
          out_nxt.cell_value     = cell_r;
          out_nxt.cursor_col     = term_r.col;
          out_nxt.cursor_row     = term_r.row;
          out_nxt.last           = !ident_r || (idx_r == 2'd2);
          if (ident_r && idx_r != 2'd2) begin
            idx_nxt = idx_r + 2'd1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      term_r      <= '0;
      ptr_row_r   <= '0;
      ptr_col_r   <= '0;
      end_row_r   <= LAST_ROW;
      up_r        <= 1'b0;
      clr_r       <= 1'b1;
      ident_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      ptr_row_r   <= ptr_row_nxt;
      ptr_col_r   <= ptr_col_nxt;
      end_row_r   <= end_row_nxt;
      up_r        <= up_nxt;
      clr_r       <= clr_nxt;
      ident_r     <= ident_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    cell_r <= cell_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tts_decode.sv =====
// Character decoder: next cursor and escape state, plus store action.
// Depends on tts_pkg; purely combinational.
`default_nettype none

module tts_decode #(
  parameter int COLUMNS = tts_pkg::COLUMNS_DEF,
  parameter int ROWS    = tts_pkg::ROWS_DEF
) (
  input  wire logic [6:0]     char_code,
  input  wire tts_pkg::term_t cur,
  output tts_pkg::act_t       act
);
  import tts_pkg::*;

  localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);
  localparam logic [6:0] TAB_EDGE = 7'(COLUMNS - 8);
  localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);

  logic [7:0] col_off;

  // Column byte of direct addressing, offset by space
  assign col_off = {1'b0, char_code} - {1'b0, CH_SPACE};

  always_comb begin
    act         = '0;
    act.nxt     = cur;
    act.wr_val  = char_code;
    act.op      = OP_NONE;
    act.end_row = cur.row;

    priority if (cur.phase == PH_ROW) begin
      act.nxt.prow  = char_code - CH_SPACE;
      act.nxt.phase = PH_COL;
    end else if (cur.phase == PH_COL) begin
      if ({1'b0, cur.prow} < 8'(ROWS)) begin
        act.nxt.row = cur.prow[4:0];
      end
      // clamp the column byte to the screen
      if (char_code < CH_SPACE) begin
        act.nxt.col = '0;
      end else if (col_off >= 8'(COLUMNS)) begin
        act.nxt.col = LAST_COL;
      end else begin
        act.nxt.col = col_off[6:0];
      end
      act.nxt.phase = PH_NONE;
    end else if (cur.esc) begin
      act.nxt.esc = 1'b0;
      unique case (char_code)
        CH_A: if (cur.row != '0) act.nxt.row = cur.row - 5'd1;
        CH_B: if (cur.row != LAST_ROW) act.nxt.row = cur.row + 5'd1;
        CH_C: if (cur.col != LAST_COL) act.nxt.col = cur.col + 7'd1;
        CH_D: if (cur.col != '0) act.nxt.col = cur.col - 7'd1;
        CH_I: begin
          if (cur.row == '0) act.op = OP_SCROLL_DN;
          else act.nxt.row = cur.row - 5'd1;
        end
        CH_H: begin
          act.nxt.row = '0;
          act.nxt.col = '0;
        end
        CH_K: begin
          act.op      = OP_FILL;
          act.end_row = cur.row;
        end
        CH_J: begin
          act.op      = OP_FILL;
          act.end_row = LAST_ROW;
        end
        CH_Y: act.nxt.phase = PH_ROW;
        CH_Z: act.ident = 1'b1;
        CH_F: act.nxt.gfx = 1'b1;
        CH_G: act.nxt.gfx = 1'b0;
        default: ;
      endcase
    end else if (char_code >= CH_SPACE) begin
      // printable: write at cursor, graphics remap of the top codes
      if (char_code != CH_DEL) begin
        act.wr_en = 1'b1;
        if (cur.gfx && char_code >= CH_GFX0) begin
          act.wr_val = (char_code == CH_GFX0) ? 7'd0 : char_code - CH_GFX1;
        end
        if (cur.col != LAST_COL) act.nxt.col = cur.col + 7'd1;
      end
    end else begin
      unique case (char_code)
        CH_HT: begin
          if (cur.col >= TAB_EDGE) begin
            if (cur.col != LAST_COL) act.nxt.col = cur.col + 7'd1;
          end else begin
            act.nxt.col = {cur.col[6:3] + 4'd1, 3'b000};
          end
        end
        CH_LF: begin
          if (cur.row == LAST_ROW) act.op = OP_SCROLL_UP;
          else act.nxt.row = cur.row + 5'd1;
        end
        CH_CR:  act.nxt.col = '0;
        CH_BS:  if (cur.col != '0) act.nxt.col = cur.col - 7'd1;
        CH_ESC: act.nxt.esc = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
